[hw/rtl/led_blink_breathe_controller_defines.svh]
// Assertion macros for the LED blink/breathe controller RTL.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef LED_BLINK_BREATHE_CONTROLLER_DEFINES_SVH
`define LED_BLINK_BREATHE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LBB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lbb_pkg.sv]
// Package of the LED blink/breathe controller: widths, reset values, register
// indexes, shared types and the timer step functions. Depends on nothing.
`default_nettype none

package lbb_pkg;

  localparam int unsigned BLINK_PRESCALE = 16;
  localparam int unsigned SLOW_PRESCALE  = 32;
  localparam int unsigned PWM_PRESCALE   = 2;
  localparam int unsigned MAX_DIVIDER    = 16;

  localparam int unsigned TW      = 16;
  localparam int unsigned DUTY_W  = 6;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned DIV_W   = 5;
  localparam int unsigned SH_W    = $clog2(DIV_W);
  localparam int unsigned PROD_W  = DUTY_W + SCALE_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PRE_MAX_A = (BLINK_PRESCALE > SLOW_PRESCALE) ?
                                      BLINK_PRESCALE : SLOW_PRESCALE;
  localparam int unsigned PRE_MAX   = (PRE_MAX_A > PWM_PRESCALE) ? PRE_MAX_A : PWM_PRESCALE;
  localparam int unsigned PRE_W     = ($clog2(PRE_MAX) > 0) ? $clog2(PRE_MAX) : 1;

  localparam logic [PRE_W:0] BLINK_SCALE = (PRE_W+1)'(BLINK_PRESCALE);
  localparam logic [PRE_W:0] SLOW_SCALE  = (PRE_W+1)'(SLOW_PRESCALE);
  localparam logic [PRE_W:0] PWM_SCALE   = (PRE_W+1)'(PWM_PRESCALE);
  localparam logic [DIV_W-1:0] DIV_MAX   = DIV_W'(MAX_DIVIDER);

  localparam logic [TW-1:0]      BLINK_BASE_RST    = 16'd62500;
  localparam logic [TW-1:0]      HOLD_LENGTH_RST   = 16'd62500;
  localparam logic [TW-1:0]      RAMP_INTERVAL_RST = 16'd3125;
  localparam logic [TW-1:0]      PWM_PERIOD_RST    = 16'd3101;
  localparam logic [DUTY_W-1:0]  DUTY_MAX_RST      = 6'd50;
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST     = 8'd61;
  localparam logic [SCALE_W-1:0] HIGH_SCALE_RST    = 8'd62;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLINK_BASE    = 3'd0,
    REG_HOLD_LENGTH   = 3'd1,
    REG_RAMP_INTERVAL = 3'd2,
    REG_PWM_PERIOD    = 3'd3,
    REG_DUTY_MAX      = 3'd4,
    REG_LOW_SCALE     = 3'd5,
    REG_HIGH_SCALE    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TW-1:0]      blink_base;
    logic [TW-1:0]      hold_length;
    logic [TW-1:0]      ramp_interval;
    logic [TW-1:0]      pwm_period;
    logic [DUTY_W-1:0]  duty_max;
    logic [SCALE_W-1:0] low_scale;
    logic [SCALE_W-1:0] high_scale;
  } cfg_t;

  typedef struct packed {
    logic              led_level;
    logic              breathing;
    logic [DUTY_W-1:0] duty_now;
    logic [DIV_W-1:0]  rate_divider;
  } result_t;

  typedef struct packed {
    logic             fire;
    logic [PRE_W-1:0] value;
  } pre_step_t;

  typedef struct packed {
    logic          fire;
    logic [TW-1:0] value;
  } cnt_step_t;

  // One base tick of a prescaler; fires and wraps to zero when it reaches the scale.
  function automatic pre_step_t tick_pre(input logic [PRE_W-1:0] pre,
                                         input logic [PRE_W:0] scale);
    pre_step_t      r;
    logic [PRE_W:0] sum;
    sum = {1'b0, pre} + (PRE_W+1)'(1);
    if (sum >= scale) begin
      r.fire  = 1'b1;
      r.value = '0;
    end else begin
      r.fire  = 1'b0;
      r.value = sum[PRE_W-1:0];
    end
    return r;
  endfunction

  // One timer unit; fires and reloads when the count reaches the limit or wraps.
  function automatic cnt_step_t count_unit(input logic [TW-1:0] cnt,
                                           input logic [TW-1:0] limit,
                                           input logic [TW-1:0] reload);
    cnt_step_t     r;
    logic [TW-1:0] nxt;
    nxt = cnt + TW'(1);
    if (nxt >= limit || nxt == '0) begin
      r.fire  = 1'b1;
      r.value = reload;
    end else begin
      r.fire  = 1'b0;
      r.value = nxt;
    end
    return r;
  endfunction

  // Bit position of a one-hot divider, used as the right shift of the blink base.
  function automatic logic [SH_W-1:0] div_shift(input logic [DIV_W-1:0] div);
    logic [SH_W-1:0] sh;
    sh = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (div[i]) begin
        sh = SH_W'(i);
      end
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lbb_cfg_regs.sv]
// Configuration registers of the LED blink/breathe controller.
// Depends on lbb_pkg.
`default_nettype none

module lbb_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lbb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lbb_pkg::TW-1:0]         cfg_data_i,
  output lbb_pkg::cfg_t                       cfg_o
);

  lbb_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_base    <= lbb_pkg::BLINK_BASE_RST;
      cfg_q.hold_length   <= lbb_pkg::HOLD_LENGTH_RST;
      cfg_q.ramp_interval <= lbb_pkg::RAMP_INTERVAL_RST;
      cfg_q.pwm_period    <= lbb_pkg::PWM_PERIOD_RST;
      cfg_q.duty_max      <= lbb_pkg::DUTY_MAX_RST;
      cfg_q.low_scale     <= lbb_pkg::LOW_SCALE_RST;
      cfg_q.high_scale    <= lbb_pkg::HIGH_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lbb_pkg::REG_BLINK_BASE:    cfg_q.blink_base    <= cfg_data_i;
        lbb_pkg::REG_HOLD_LENGTH:   cfg_q.hold_length   <= cfg_data_i;
        lbb_pkg::REG_RAMP_INTERVAL: cfg_q.ramp_interval <= cfg_data_i;
        lbb_pkg::REG_PWM_PERIOD:    cfg_q.pwm_period    <= cfg_data_i;
        lbb_pkg::REG_DUTY_MAX:      cfg_q.duty_max      <= cfg_data_i[lbb_pkg::DUTY_W-1:0];
        lbb_pkg::REG_LOW_SCALE:     cfg_q.low_scale     <= cfg_data_i[lbb_pkg::SCALE_W-1:0];
        lbb_pkg::REG_HIGH_SCALE:    cfg_q.high_scale    <= cfg_data_i[lbb_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lbb_in_reg.sv]
// Input register of the LED blink/breathe controller: holds one button sample
// until the tick logic takes it. Depends on nothing.
`default_nettype none

module lbb_in_reg (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire logic button_i,
  input  wire logic take_i,
  output logic      valid_o,
  output logic      button_o
);

  logic valid_q;
  logic valid_d;
  logic button_q;

  assign ready_o  = !valid_q || take_i;
  assign valid_o  = valid_q;
  assign button_o = button_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      button_q <= button_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lbb_step.sv]
// Per-tick state and next-state logic of the LED blink/breathe controller:
// button edges, hold, blink, ramp and PWM timers. Depends on lbb_pkg and the defines header.
`default_nettype none
`include "led_blink_breathe_controller_defines.svh"

module lbb_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          button_i,
  input  wire lbb_pkg::cfg_t cfg_i,
  output lbb_pkg::result_t   result_o
);

  logic                          led_q, led_d;
  logic                          mode_q, mode_d;
  logic [lbb_pkg::DIV_W-1:0]     div_q, div_d;
  logic [lbb_pkg::TW-1:0]        limit_q, limit_d;
  logic [lbb_pkg::TW-1:0]        blink_cnt_q, blink_cnt_d;
  logic [lbb_pkg::PRE_W-1:0]     fast_pre_q, fast_pre_d;
  logic                          hold_act_q, hold_act_d;
  logic                          await_q, await_d;
  logic [lbb_pkg::TW-1:0]        hold_cnt_q, hold_cnt_d;
  logic [lbb_pkg::TW-1:0]        ramp_cnt_q, ramp_cnt_d;
  logic [lbb_pkg::TW-1:0]        pwm_cnt_q, pwm_cnt_d;
  logic [lbb_pkg::DUTY_W-1:0]    duty_q, duty_d;
  logic                          rising_q, rising_d;
  logic [lbb_pkg::PRE_W-1:0]     hold_pre_q, hold_pre_d;
  logic [lbb_pkg::PRE_W-1:0]     pwm_pre_q, pwm_pre_d;
  logic                          last_btn_q, last_btn_d;

  logic [lbb_pkg::DIV_W-1:0]     div_dbl;
  lbb_pkg::pre_step_t            hold_ps, fast_ps, pwm_ps;
  lbb_pkg::cnt_step_t            hold_cs, fast_cs, pwm_cs;
  logic [lbb_pkg::SCALE_W-1:0]   pwm_scale;
  logic [lbb_pkg::PROD_W-1:0]    pwm_prod;
  logic [lbb_pkg::TW-1:0]        prod_ext;
  logic [lbb_pkg::TW-1:0]        start_high;
  logic [lbb_pkg::TW-1:0]        pwm_reload;

  always_comb begin
    led_d       = led_q;
    mode_d      = mode_q;
    div_d       = div_q;
    limit_d     = limit_q;
    blink_cnt_d = blink_cnt_q;
    fast_pre_d  = fast_pre_q;
    hold_act_d  = hold_act_q;
    await_d     = await_q;
    hold_cnt_d  = hold_cnt_q;
    ramp_cnt_d  = ramp_cnt_q;
    pwm_cnt_d   = pwm_cnt_q;
    duty_d      = duty_q;
    rising_d    = rising_q;
    hold_pre_d  = hold_pre_q;
    pwm_pre_d   = pwm_pre_q;
    div_dbl     = {div_q[lbb_pkg::DIV_W-2:0], 1'b0};
    hold_ps     = '0;
    hold_cs     = '0;
    fast_ps     = '0;
    fast_cs     = '0;
    pwm_ps      = '0;
    pwm_cs      = '0;
    pwm_scale   = '0;
    pwm_prod    = '0;
    prod_ext    = '0;
    start_high  = '0;
    pwm_reload  = '0;

    // A press is taken only when no release is pending and no hold is running.
    if (!await_q && last_btn_q && !button_i) begin
      if (!hold_act_q) begin
        if (div_dbl > lbb_pkg::DIV_MAX || div_dbl == '0) begin
          div_dbl = lbb_pkg::DIV_W'(1);
        end
        div_d      = div_dbl;
        limit_d    = cfg_i.blink_base >> lbb_pkg::div_shift(div_dbl);
        await_d    = 1'b1;
        hold_act_d = 1'b1;
        hold_cnt_d = '0;
        hold_pre_d = '0;
        if (mode_q) begin
          blink_cnt_d = '0;
          fast_pre_d  = '0;
          pwm_cnt_d   = '0;
          pwm_pre_d   = '0;
        end
        mode_d = 1'b0;
      end
    end else if (await_q && !last_btn_q && button_i) begin
      hold_act_d = 1'b0;
      hold_cnt_d = '0;
      hold_pre_d = '0;
      await_d    = 1'b0;
    end

    if (hold_act_d) begin
      hold_ps    = lbb_pkg::tick_pre(hold_pre_d, lbb_pkg::SLOW_SCALE);
      hold_pre_d = hold_ps.value;
      if (hold_ps.fire) begin
        hold_cs    = lbb_pkg::count_unit(hold_cnt_d, cfg_i.hold_length, '0);
        hold_cnt_d = hold_cs.value;
        if (hold_cs.fire) begin
          hold_act_d = 1'b0;
          hold_cnt_d = '0;
          if (!button_i) begin
            mode_d     = 1'b1;
            ramp_cnt_d = '0;
            fast_pre_d = '0;
            pwm_cnt_d  = '0;
            pwm_pre_d  = '0;
          end
        end
      end
    end

    if (!mode_d) begin
      fast_ps    = lbb_pkg::tick_pre(fast_pre_d, lbb_pkg::BLINK_SCALE);
      fast_pre_d = fast_ps.value;
      if (fast_ps.fire) begin
        fast_cs     = lbb_pkg::count_unit(blink_cnt_d, limit_d, '0);
        blink_cnt_d = fast_cs.value;
        if (fast_cs.fire) begin
          led_d = !led_d;
        end
      end
    end else begin
      fast_ps    = lbb_pkg::tick_pre(fast_pre_d, lbb_pkg::SLOW_SCALE);
      fast_pre_d = fast_ps.value;
      if (fast_ps.fire) begin
        fast_cs    = lbb_pkg::count_unit(ramp_cnt_d, cfg_i.ramp_interval, '0);
        ramp_cnt_d = fast_cs.value;
        if (fast_cs.fire) begin
          if (rising_d) begin
            if (duty_d < cfg_i.duty_max) begin
              duty_d = duty_d + lbb_pkg::DUTY_W'(1);
            end else begin
              rising_d = 1'b0;
            end
          end else begin
            if (duty_d > lbb_pkg::DUTY_W'(1)) begin
              duty_d = duty_d - lbb_pkg::DUTY_W'(1);
            end else begin
              rising_d = 1'b1;
            end
          end
        end
      end

      // The reload of the PWM count depends on the phase that is ending.
      pwm_ps    = lbb_pkg::tick_pre(pwm_pre_d, lbb_pkg::PWM_SCALE);
      pwm_pre_d = pwm_ps.value;
      if (pwm_ps.fire) begin
        pwm_scale = led_d ? cfg_i.low_scale : cfg_i.high_scale;
        pwm_prod  = lbb_pkg::PROD_W'(duty_d) * lbb_pkg::PROD_W'(pwm_scale);
        prod_ext  = lbb_pkg::TW'(pwm_prod);
        if (prod_ext > cfg_i.pwm_period) begin
          start_high = '0;
        end else begin
          start_high = cfg_i.pwm_period - prod_ext;
        end
        pwm_reload = led_d ? prod_ext : start_high;
        pwm_cs     = lbb_pkg::count_unit(pwm_cnt_d, cfg_i.pwm_period, pwm_reload);
        pwm_cnt_d  = pwm_cs.value;
        if (pwm_cs.fire) begin
          led_d = !led_d;
        end
      end
    end
  end

  assign last_btn_d = button_i;

  assign result_o.led_level    = led_d;
  assign result_o.breathing    = mode_d;
  assign result_o.duty_now     = duty_d;
  assign result_o.rate_divider = div_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q       <= 1'b0;
      mode_q      <= 1'b0;
      div_q       <= lbb_pkg::DIV_W'(1);
      limit_q     <= lbb_pkg::BLINK_BASE_RST;
      blink_cnt_q <= '0;
      fast_pre_q  <= '0;
      hold_act_q  <= 1'b0;
      await_q     <= 1'b0;
      hold_cnt_q  <= '0;
      ramp_cnt_q  <= '0;
      pwm_cnt_q   <= '0;
      duty_q      <= '0;
      rising_q    <= 1'b1;
      hold_pre_q  <= '0;
      pwm_pre_q   <= '0;
      last_btn_q  <= 1'b1;
    end else if (step_i) begin
      led_q       <= led_d;
      mode_q      <= mode_d;
      div_q       <= div_d;
      limit_q     <= limit_d;
      blink_cnt_q <= blink_cnt_d;
      fast_pre_q  <= fast_pre_d;
      hold_act_q  <= hold_act_d;
      await_q     <= await_d;
      hold_cnt_q  <= hold_cnt_d;
      ramp_cnt_q  <= ramp_cnt_d;
      pwm_cnt_q   <= pwm_cnt_d;
      duty_q      <= duty_d;
      rising_q    <= rising_d;
      hold_pre_q  <= hold_pre_d;
      pwm_pre_q   <= pwm_pre_d;
      last_btn_q  <= last_btn_d;
    end
  end

  `LBB_ASSERT_IMPL(a_div_onehot, 1'b1, $onehot(div_q), "blink divider is not a power of two")
  `LBB_ASSERT_IMPL(a_hold_needs_press, hold_act_q, await_q, "hold timer runs without a press")
  `LBB_ASSERT_NEXT(a_blink_duty_kept, step_i && !mode_d, duty_q == $past(duty_q), "duty moved in blink mode")

endmodule

`default_nettype wire

[hw/rtl/lbb_out_reg.sv]
// Result register of the LED blink/breathe controller: holds one result item
// until the downstream side takes it. Depends on lbb_pkg.
`default_nettype none

module lbb_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  output logic                  can_load_o,
  input  wire lbb_pkg::result_t result_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output lbb_pkg::result_t      result_o
);

  logic             valid_q;
  logic             valid_d;
  lbb_pkg::result_t result_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign result_o   = result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/led_blink_breathe_controller.sv]
// Top level of the LED blink/breathe controller: configuration registers,
// input register, tick logic and result register. Depends on lbb_pkg and the lbb_* modules.
//
// Each input item is one base clock tick carrying the sampled button level, and
// it yields exactly one result item with the LED level, the mode, the ramp duty
// and the blink divider after that tick. The block takes one item per clock
// cycle while the result register is empty or its result is being taken; an
// accepted item is held in the input register, and its result is loaded into
// the result register, which offers it downstream. The tick logic between those
// two registers is combinational. Configuration writes are taken at any time
// but should only be made while no item is in flight.
`default_nettype none

module led_blink_breathe_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lbb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lbb_pkg::TW-1:0]        cfg_data_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [0] button_level
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] led_level, [1] breathing, [7:2] duty_now, [12:8] rate_divider
  output logic [15:0]                        m_axis_tdata_o
);

  lbb_pkg::cfg_t    cfg;
  lbb_pkg::result_t step_result;
  lbb_pkg::result_t out_result;
  logic             in_valid;
  logic             in_button;
  logic             can_load;
  logic             step_fire;

  assign step_fire = in_valid && can_load;

  lbb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lbb_in_reg u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .button_i (s_axis_tdata_i[0]),
    .take_i   (step_fire),
    .valid_o  (in_valid),
    .button_o (in_button)
  );

  lbb_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step_fire),
    .button_i (in_button),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  lbb_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step_fire),
    .can_load_o (can_load),
    .result_i   (step_result),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .result_o   (out_result)
  );

  assign m_axis_tdata_o = {3'b000, out_result.rate_divider, out_result.duty_now,
                           out_result.breathing, out_result.led_level};

endmodule

`default_nettype wire
